// ===== hw/rtl/refactorable_number_counter_assert.svh =====
// assertion macros for the refactorable number counter
// included by the top level; empty bodies when SYNTHESIS is defined
`ifndef REFACTORABLE_NUMBER_COUNTER_ASSERT_SVH
`define REFACTORABLE_NUMBER_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define RNC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define RNC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define RNC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RNC_ASSERT(lbl, clk, rstn, prop, msg)
`define RNC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define RNC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/rnc_pkg.sv =====
// microcode types, action and jump codes, and the control program
// of the refactorable number counter; no dependencies
`default_nettype none

package rnc_pkg;

    localparam int STEP_W = 5;
    localparam int ACT_W  = 5;
    localparam int COND_W = 4;

    typedef logic [STEP_W-1:0] step_t;
    typedef logic [ACT_W-1:0]  act_t;
    typedef logic [COND_W-1:0] cond_t;

    // one control word: datapath action, jump condition, jump target
    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // datapath actions
    localparam act_t A_WAIT       = 5'd0;
    localparam act_t A_CLEAR      = 5'd1;
    localparam act_t A_SIEVE_INIT = 5'd2;
    localparam act_t A_RD_I       = 5'd3;
    localparam act_t A_MARK_PRIME = 5'd4;
    localparam act_t A_SQ_SETUP   = 5'd5;
    localparam act_t A_RD_J       = 5'd6;
    localparam act_t A_MARK_J     = 5'd7;
    localparam act_t A_NEXT_I     = 5'd8;
    localparam act_t A_CNT_INIT   = 5'd9;
    localparam act_t A_C_RD_M     = 5'd10;
    localparam act_t A_C_CHK      = 5'd11;
    localparam act_t A_C_ADD      = 5'd12;
    localparam act_t A_T_INIT     = 5'd13;
    localparam act_t A_T_RD       = 5'd14;
    localparam act_t A_T_LOAD     = 5'd15;
    localparam act_t A_T_REM      = 5'd16;
    localparam act_t A_T_TALLY    = 5'd17;
    localparam act_t A_OUT        = 5'd18;
    localparam act_t A_NOP        = 5'd19;

    // jump conditions; when false the step counter just advances
    localparam cond_t C_NEXT     = 4'd0;
    localparam cond_t C_ALWAYS   = 4'd1;
    localparam cond_t C_NO_BEAT  = 4'd2;
    localparam cond_t C_I_LT_HI  = 4'd3;
    localparam cond_t C_I_GT_HI  = 4'd4;
    localparam cond_t C_LF_NZ    = 4'd5;
    localparam cond_t C_SQ_GT_HI = 4'd6;
    localparam cond_t C_J_GT_HI  = 4'd7;
    localparam cond_t C_LF_NE_P  = 4'd8;
    localparam cond_t C_LO_GT_HI = 4'd9;
    localparam cond_t C_BIT_MORE = 4'd10;
    localparam cond_t C_OUT_BUSY = 4'd11;

    // program steps
    localparam step_t S_WAIT     = 5'd0;
    localparam step_t S_CLEAR    = 5'd1;
    localparam step_t S_SV_INIT  = 5'd2;
    localparam step_t S_SV_RD    = 5'd3;
    localparam step_t S_SV_PRIME = 5'd4;
    localparam step_t S_SV_SQ    = 5'd5;
    localparam step_t S_SV_RDJ   = 5'd6;
    localparam step_t S_SV_MARK  = 5'd7;
    localparam step_t S_SV_NEXT  = 5'd8;
    localparam step_t S_CT_INIT  = 5'd9;
    localparam step_t S_CT_RD    = 5'd10;
    localparam step_t S_CT_RDM   = 5'd11;
    localparam step_t S_CT_CHK   = 5'd12;
    localparam step_t S_CT_ADD   = 5'd13;
    localparam step_t S_CT_NEXT  = 5'd14;
    localparam step_t S_TS_INIT  = 5'd15;
    localparam step_t S_TS_RD    = 5'd16;
    localparam step_t S_TS_LOAD  = 5'd17;
    localparam step_t S_TS_REM   = 5'd18;
    localparam step_t S_TS_TALLY = 5'd19;
    localparam step_t S_DONE     = 5'd20;
    localparam step_t S_RET      = 5'd21;
    localparam step_t S_LAST     = S_RET;

    // control store
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        unique case (s)
            S_WAIT:     w = '{A_WAIT,       C_NO_BEAT,  S_WAIT};
            S_CLEAR:    w = '{A_CLEAR,      C_I_LT_HI,  S_CLEAR};
            S_SV_INIT:  w = '{A_SIEVE_INIT, C_NEXT,     S_WAIT};
            S_SV_RD:    w = '{A_RD_I,       C_I_GT_HI,  S_CT_INIT};
            S_SV_PRIME: w = '{A_MARK_PRIME, C_LF_NZ,    S_SV_NEXT};
            S_SV_SQ:    w = '{A_SQ_SETUP,   C_SQ_GT_HI, S_SV_NEXT};
            S_SV_RDJ:   w = '{A_RD_J,       C_J_GT_HI,  S_SV_NEXT};
            S_SV_MARK:  w = '{A_MARK_J,     C_ALWAYS,   S_SV_RDJ};
            S_SV_NEXT:  w = '{A_NEXT_I,     C_ALWAYS,   S_SV_RD};
            S_CT_INIT:  w = '{A_CNT_INIT,   C_NEXT,     S_WAIT};
            S_CT_RD:    w = '{A_RD_I,       C_I_GT_HI,  S_TS_INIT};
            S_CT_RDM:   w = '{A_C_RD_M,     C_NEXT,     S_WAIT};
            S_CT_CHK:   w = '{A_C_CHK,      C_LF_NE_P,  S_CT_NEXT};
            S_CT_ADD:   w = '{A_C_ADD,      C_NEXT,     S_WAIT};
            S_CT_NEXT:  w = '{A_NEXT_I,     C_ALWAYS,   S_CT_RD};
            S_TS_INIT:  w = '{A_T_INIT,     C_LO_GT_HI, S_DONE};
            S_TS_RD:    w = '{A_T_RD,       C_I_GT_HI,  S_DONE};
            S_TS_LOAD:  w = '{A_T_LOAD,     C_NEXT,     S_WAIT};
            S_TS_REM:   w = '{A_T_REM,      C_BIT_MORE, S_TS_REM};
            S_TS_TALLY: w = '{A_T_TALLY,    C_ALWAYS,   S_TS_RD};
            S_DONE:     w = '{A_OUT,        C_OUT_BUSY, S_DONE};
            S_RET:      w = '{A_NOP,        C_ALWAYS,   S_WAIT};
            default:    w = '{A_NOP,        C_ALWAYS,   S_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/refactorable_number_counter.sv =====
// refactorable number counter: one query (low, high) in, one count out.
// microcoded sequencer over four stores (one read, one write port each); uses rnc_pkg.
//
// usage:
//   s_ channel: one beat per query, tdata = {range_high, range_low}.
//   m_ channel: one beat per query, tdata = refactorable_count.
//   a query runs four phases on one shared datapath, one control word a cycle:
//     clear of the least-factor store over 0..high
//     sieve: least prime factor and cofactor of each index 2..high
//     divisor counts from the cofactor store
//     test n mod d(n), one remainder bit per cycle
//   NW is the address width, clog2(MAX_N+1); the sequencer runs one query at a time.
//   the result sits in an output register: a new query is taken while it
//   waits, and the sequencer holds at its output step only if a second result
//   is ready before the first is taken.
//   reset (aresetn low, synchronous) returns the sequencer to its wait step
//   and drops m_tvalid; the stores keep their contents and need no clearing.
`default_nettype none

`include "refactorable_number_counter_assert.svh"

module refactorable_number_counter
    import rnc_pkg::*;
#(
    parameter int MAX_N = 65535
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] range_low, [31:16] range_high
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [15:0] refactorable_count
);

    localparam int NW  = $clog2(MAX_N + 1);
    // widest divisor count below the limit
    localparam int DW  = (MAX_N >= 1081080) ? 9 : ((MAX_N >= 83160) ? 8 : 7);
    localparam int BCW = $clog2(NW);
    localparam logic [BCW-1:0] BC_LAST = BCW'(NW - 1);

    // stores
    logic [NW-1:0] lf_mem [0:MAX_N];    // least prime factor
    logic [NW-1:0] cf_mem [0:MAX_N];    // n / least prime factor
    logic [NW-1:0] rs_mem [0:MAX_N];    // n with its least prime fully stripped
    logic [DW-1:0] dc_mem [0:MAX_N];    // divisor count

    logic [NW-1:0] lf_rd, cf_rd, rs_rd;
    logic [DW-1:0] dc_rd;

    // sequencer
    step_t step_reg, step_next;
    ctrl_t ctrl;
    logic  jump;

    // datapath
    logic [15:0]     lo_reg;
    logic [NW-1:0]   hi_reg;
    logic [NW:0]     i_reg, j_reg;
    logic [NW-1:0]   k_reg, p_reg, m_reg, rsm_reg, sh_reg;
    logic [2*NW-1:0] sq_reg;
    logic [DW-1:0]   dcm_reg, d_reg, rem_reg;
    logic [BCW-1:0]  bc_reg;
    logic [15:0]     cnt_reg, out_reg;
    logic            out_valid_reg;

    logic            beat, out_busy;
    logic [31:0]     hi_in;
    logic [15:0]     lo_in;
    logic [NW-1:0]   ra, dc_ra;
    logic            lf_we, cf_we, rs_we, dc_we;
    logic [NW-1:0]   lf_wa, lf_wd, cf_wd, rs_wd, dc_wa;
    logic [DW-1:0]   dc_wd;
    logic [DW:0]     rem_t;
    logic [DW-1:0]   dc_dbl;
    logic [NW-1:0]   i_lo;

    assign ctrl     = ucode(step_reg);
    assign s_tready = (ctrl.act == A_WAIT);
    assign beat     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign out_busy = out_valid_reg && !m_tready;
    assign i_lo     = i_reg[NW-1:0];
    assign hi_in    = {16'd0, s_tdata[31:16]};
    assign lo_in    = s_tdata[15:0];
    assign rem_t    = {rem_reg, sh_reg[NW-1]};
    assign dc_dbl   = {dc_rd[DW-2:0], 1'b0};

    always_comb begin
        unique case (ctrl.cond)
            C_NEXT:     jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_BEAT:  jump = !s_tvalid;
            C_I_LT_HI:  jump = (i_reg < {1'b0, hi_reg});
            C_I_GT_HI:  jump = (i_reg > {1'b0, hi_reg});
            C_LF_NZ:    jump = (lf_rd != '0);
            C_SQ_GT_HI: jump = (sq_reg > (2*NW)'(hi_reg));
            C_J_GT_HI:  jump = (j_reg > {1'b0, hi_reg});
            C_LF_NE_P:  jump = (lf_rd != p_reg);
            C_LO_GT_HI: jump = (32'(lo_reg) > 32'(hi_reg));
            C_BIT_MORE: jump = (bc_reg != BC_LAST);
            C_OUT_BUSY: jump = out_busy;
            default:    jump = 1'b0;
        endcase
        step_next = jump ? ctrl.target : step_t'(step_reg + 1'b1);
    end

    // memory addresses and write strobes
    always_comb begin
        ra    = i_lo;
        dc_ra = i_lo;
        lf_we = 1'b0;
        cf_we = 1'b0;
        rs_we = 1'b0;
        dc_we = 1'b0;
        lf_wa = i_lo;
        lf_wd = '0;
        cf_wd = NW'(1);
        rs_wd = m_reg;
        dc_wa = i_lo;
        dc_wd = dc_dbl;
        unique case (ctrl.act)
            A_CLEAR: begin
                lf_we = 1'b1;
            end
            A_MARK_PRIME: begin
                lf_we = (lf_rd == '0);
                cf_we = (lf_rd == '0);
                lf_wd = i_lo;
            end
            A_RD_J: begin
                ra = j_reg[NW-1:0];
            end
            A_MARK_J: begin
                // only the first (smallest) prime to reach an index claims it
                lf_we = (lf_rd == '0);
                cf_we = (lf_rd == '0);
                lf_wa = j_reg[NW-1:0];
                lf_wd = i_lo;
                cf_wd = k_reg;
            end
            A_CNT_INIT: begin
                dc_we = 1'b1;
                dc_wa = NW'(1);
                dc_wd = DW'(1);
            end
            A_C_RD_M: begin
                ra    = cf_rd;
                dc_ra = cf_rd;
            end
            A_C_CHK: begin
                // cofactor not divisible by p: d(n) = 2 * d(m), rest is m
                dc_ra = rs_rd;
                rs_we = (lf_rd != p_reg);
                dc_we = (lf_rd != p_reg);
            end
            A_C_ADD: begin
                // one more power of p: d(n) = d(m) + d(rest(m))
                rs_we = 1'b1;
                dc_we = 1'b1;
                rs_wd = rsm_reg;
                dc_wd = dcm_reg + dc_rd;
            end
            default: begin
            end
        endcase
    end

    // lf, cf and rs share one read address
    always_ff @(posedge aclk) begin
        if (lf_we) begin
            lf_mem[lf_wa] <= lf_wd;
        end
        lf_rd <= lf_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (cf_we) begin
            cf_mem[lf_wa] <= cf_wd;
        end
        cf_rd <= cf_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (rs_we) begin
            rs_mem[i_lo] <= rs_wd;
        end
        rs_rd <= rs_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (dc_we) begin
            dc_mem[dc_wa] <= dc_wd;
        end
        dc_rd <= dc_mem[dc_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= S_WAIT;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (ctrl.act == A_OUT && !out_busy) begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (ctrl.act)
            A_WAIT: begin
                if (beat) begin
                    lo_reg <= (lo_in == 16'd0) ? 16'd1 : lo_in;
                    hi_reg <= (hi_in > 32'(MAX_N)) ? NW'(MAX_N) : hi_in[NW-1:0];
                    i_reg  <= '0;
                end
            end
            A_CLEAR: begin
                i_reg <= i_reg + 1'b1;
            end
            A_SIEVE_INIT, A_CNT_INIT: begin
                i_reg <= (NW+1)'(2);
            end
            A_MARK_PRIME: begin
                sq_reg <= i_lo * i_lo;
            end
            A_SQ_SETUP: begin
                j_reg <= sq_reg[NW:0];
                k_reg <= i_lo;
            end
            A_MARK_J: begin
                j_reg <= j_reg + i_reg;
                k_reg <= k_reg + 1'b1;
            end
            A_NEXT_I: begin
                i_reg <= i_reg + 1'b1;
            end
            A_C_RD_M: begin
                p_reg <= lf_rd;
                m_reg <= cf_rd;
            end
            A_C_CHK: begin
                dcm_reg <= dc_rd;
                rsm_reg <= rs_rd;
            end
            A_T_INIT: begin
                i_reg   <= (NW+1)'(lo_reg);
                cnt_reg <= '0;
            end
            A_T_LOAD: begin
                d_reg   <= dc_rd;
                rem_reg <= '0;
                sh_reg  <= i_lo;
                bc_reg  <= '0;
            end
            A_T_REM: begin
                // restoring remainder, one bit of n per cycle
                if (rem_t >= {1'b0, d_reg}) begin
                    rem_reg <= DW'(rem_t - {1'b0, d_reg});
                end else begin
                    rem_reg <= rem_t[DW-1:0];
                end
                sh_reg <= {sh_reg[NW-2:0], 1'b0};
                bc_reg <= bc_reg + 1'b1;
            end
            A_T_TALLY: begin
                if (rem_reg == '0) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                i_reg <= i_reg + 1'b1;
            end
            A_OUT: begin
                if (!out_busy) begin
                    out_reg <= cnt_reg;
                end
            end
            default: begin
            end
        endcase
    end

    `RNC_ASSERT(a_step_in_program, aclk, aresetn, step_reg <= S_LAST, "step out of program")
    `RNC_ASSERT_NEXT(a_beat_starts_clear, aclk, aresetn, beat, step_reg == S_CLEAR, "no clear")
    `RNC_ASSERT_IMPL(a_lf_write_in_range, aclk, aresetn, lf_we, lf_wa <= hi_reg, "lf above high")
    `RNC_ASSERT_IMPL(a_count_nonzero, aclk, aresetn, ctrl.act == A_T_LOAD, dc_rd != '0, "zero d")

endmodule

`default_nettype wire

// ===== tb/sv/tb_refactorable_number_counter.sv =====
// testbench for refactorable_number_counter: range queries in on the s_ stream,
// counts out on the m_ stream, checked against a trial-division count
// depends only on the dut source files
`timescale 1ns / 1ps

module tb_refactorable_number_counter;

    localparam int          CLK_HALF    = 4;
    localparam int          RESET_LEN   = 9;
    localparam int          TAIL_CYCLES = 50;
    localparam longint      CYCLE_LIMIT = 10_000_000;

    // holds the count each accepted query should produce, oldest first
    class refactorable_scoreboard;
        logic [15:0] expected_counts[$];
        int unsigned mismatches = 0;

        function int unsigned divisor_count(int unsigned n);
            int unsigned x;
            int unsigned d;
            int unsigned e;
            int unsigned p;
            x = n;
            d = 1;
            for (p = 2; p * p <= x; p++) begin
                e = 0;
                while (x % p == 0) begin
                    x = x / p;
                    e++;
                end
                d = d * (e + 1);
            end
            if (x > 1)
                d = d * 2;
            return d;
        endfunction

        function void note_query(logic [15:0] lo, logic [15:0] hi);
            int unsigned first;
            int unsigned total;
            int unsigned n;
            first = (lo == 0) ? 1 : lo;
            total = 0;
            for (n = first; n <= hi; n++) begin
                if (n % divisor_count(n) == 0)
                    total++;
            end
            expected_counts.push_back(total[15:0]);
        endfunction

        function void check_count(logic [15:0] got);
            logic [15:0] want;
            if (expected_counts.size() == 0) begin
                $error("refactorable_count: no result expected, got %0d", got);
                mismatches++;
            end else begin
                want = expected_counts.pop_front();
                if (got !== want) begin
                    $error("refactorable_count: expected %0d, got %0d", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] range_low, [31:16] range_high
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;   // [15:0] refactorable_count

    refactorable_scoreboard sb;
    int     sender_idle_pct;
    int     recv_stall_pct;
    longint cycles = 0;

    refactorable_number_counter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, every accepted beat goes to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_count(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_query(input logic [15:0] lo, input logic [15:0] hi);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
        sb.note_query(lo, hi);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        logic [15:0] lo;
        logic [15:0] hi;
        int          pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                hi = 16'($urandom_range(300, 1));
                lo = 16'($urandom_range(hi, 1));
            end else if (pick < 75) begin
                // larger sieve, short tested span to keep the run bounded
                hi = 16'($urandom_range(3000, 300));
                lo = hi - 16'($urandom_range(200, 0));
            end else if (pick < 88) begin
                // empty range, low anywhere above high
                hi = 16'($urandom_range(300, 1));
                lo = 16'($urandom_range(65535, hi + 1));
            end else begin
                lo = 16'($urandom_range(500, 1));
                hi = lo;
            end
            send_query(lo, hi);
        end
    endtask

    initial begin
        sb = new();
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;

        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: smallest ranges, known refactorable points, empty ranges,
        // widest low and high values
        send_query(16'd1, 16'd1);
        send_query(16'd1, 16'd2);
        send_query(16'd1, 16'd12);
        send_query(16'd12, 16'd12);
        send_query(16'd18, 16'd18);
        send_query(16'd96, 16'd96);
        send_query(16'd7, 16'd7);
        send_query(16'd1024, 16'd1024);
        send_query(16'd2, 16'd1);
        send_query(16'd65535, 16'd1);
        send_query(16'd65535, 16'd300);
        send_query(16'd1, 16'd100);
        send_query(16'd100, 16'd100);
        send_query(16'd1, 16'd500);
        send_query(16'd480, 16'd520);
        send_query(16'd1, 16'd2000);
        send_query(16'd2, 16'd2);
        send_query(16'd65000, 16'd65535);
        send_query(16'd3, 16'd3);
        wait_drained();

        run_random(25);
        wait_drained();

        sender_idle_pct = 63;
        recv_stall_pct  = 0;
        run_random(25);
        wait_drained();

        sender_idle_pct = 0;
        recv_stall_pct  = 63;
        run_random(25);
        wait_drained();

        sender_idle_pct = 24;
        recv_stall_pct  = 24;
        run_random(25);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
